>>> design/ial_pkg.sv
`default_nettype none

package ial_pkg;

  // Sizing
  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  // Index and count compare width, wide enough for the 7-bit count field too
  localparam int CMP_W         = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Operation codes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_ERASE  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;
  localparam logic [2:0] OP_WRITE  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [CMP_W-1:0]         pos_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic       upd;
    logic [2:0] op;
    pos_t       pos;
    elem_t      val;
    pos_t       cnt;
  } cell_cmd_t;

  // Search token that walks the chain one cell per cycle
  typedef struct packed {
    logic  active;
    logic  is_find;
    pos_t  pos;
    elem_t val;
    logic  hit;
    pos_t  hit_idx;
    elem_t rdata;
  } probe_t;

  // Element field to stored width (zero-extend or truncate)
  function automatic elem_t to_elem(input logic [31:0] e);
    logic [63:0] w;
    w = {32'd0, e};
    return w[ELEMENT_WIDTH-1:0];
  endfunction

  // Stored element to the 32-bit result field
  function automatic logic [31:0] from_elem(input elem_t x);
    logic [63:0] w;
    w = '0;
    w[ELEMENT_WIDTH-1:0] = x;
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

>>> design/ial_req_if.sv
`default_nettype none

interface ial_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [5:0]  position;
  logic [31:0] element;

  modport source (output valid, output mode, output position, output element, input ready);
  modport sink   (input valid, input mode, input position, input element, output ready);
endinterface

`default_nettype wire

>>> design/ial_rsp_if.sv
`default_nettype none

interface ial_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic        found;
  logic [5:0]  found_index;
  logic [6:0]  item_count;

  modport source (output valid, output status, output read_value, output found,
                  output found_index, output item_count, input ready);
  modport sink   (input valid, input status, input read_value, input found,
                  input found_index, input item_count, output ready);
endinterface

`default_nettype wire

>>> design/ial_cell.sv
`default_nettype none

module ial_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ial_pkg::pos_t      cell_idx,
  input  wire ial_pkg::cell_cmd_t cmd,
  input  wire ial_pkg::elem_t     prev_entry,
  input  wire ial_pkg::elem_t     next_entry,
  output ial_pkg::elem_t          entry,
  input  wire ial_pkg::probe_t    probe_in,
  output ial_pkg::probe_t         probe_out
);

  ial_pkg::elem_t  entry_next;
  ial_pkg::probe_t probe_next;
  logic            hit_here;

  // Local update: take the new value or a neighbor's entry
  always_comb begin
    entry_next = entry;
    if (cmd.upd) begin
      unique case (cmd.op)
        ial_pkg::OP_APPEND: begin
          if (cell_idx == cmd.cnt) entry_next = cmd.val;
        end
        ial_pkg::OP_INSERT: begin
          if (cell_idx == cmd.pos) entry_next = cmd.val;
          else if (cell_idx > cmd.pos && cell_idx <= cmd.cnt) entry_next = prev_entry;
        end
        ial_pkg::OP_ERASE: begin
          if (cell_idx >= cmd.pos && (cell_idx + ial_pkg::pos_t'(1)) < cmd.cnt)
            entry_next = next_entry;
        end
        ial_pkg::OP_WRITE: begin
          if (cell_idx == cmd.pos) entry_next = cmd.val;
        end
        default: entry_next = entry;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // Probe: first hit along the chain wins
  always_comb begin
    hit_here = probe_in.is_find ? (entry == probe_in.val && cell_idx < cmd.cnt)
                                : (cell_idx == probe_in.pos);
    probe_next = probe_in;
    if (!probe_in.hit && hit_here) begin
      probe_next.hit     = 1'b1;
      probe_next.hit_idx = cell_idx;
      probe_next.rdata   = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

`default_nettype wire

>>> design/ial_chain.sv
`default_nettype none

module ial_chain (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ial_pkg::cell_cmd_t cmd,
  input  wire ial_pkg::probe_t    probe_in,
  output ial_pkg::probe_t         probe_out
);

  ial_pkg::elem_t  ent   [ial_pkg::CAPACITY];
  ial_pkg::probe_t probe [ial_pkg::CAPACITY+1];

  assign probe[0]  = probe_in;
  assign probe_out = probe[ial_pkg::CAPACITY];

  // Row of cells; the ends see zero neighbors, which are never selected
  for (genvar i = 0; i < ial_pkg::CAPACITY; i++) begin : g_cell
    ial_pkg::elem_t prev_e;
    ial_pkg::elem_t next_e;

    if (i == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_prev
      assign prev_e = ent[i-1];
    end

    if (i == ial_pkg::CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_next
      assign next_e = ent[i+1];
    end

    ial_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (ial_pkg::pos_t'(i)),
      .cmd        (cmd),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (ent[i]),
      .probe_in   (probe[i]),
      .probe_out  (probe[i+1])
    );
  end

endmodule

`default_nettype wire

>>> design/indexed_array_list.sv
// Append, insert, erase, write and the unused modes: result the cycle after the transaction.
// Read and find: the result is registered once the probe has walked the cell chain,
// one cell per cycle, through every cell register.
// One operation at a time: a new request is taken the cycle after its result is taken.
// Reset (synchronous, active high) empties the list and clears control state;
// element storage is not cleared and no clearing pass runs.
`default_nettype none

module indexed_array_list (
  input wire logic clk,
  input wire logic rst,
  ial_req_if.sink  req,
  ial_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [ial_pkg::CNT_W-1:0] count;
  logic [ial_pkg::CNT_W-1:0] count_next;

  logic [1:0]  status_q;
  logic [31:0] rd_q;
  logic        found_q;
  logic [5:0]  fidx_q;

  logic               accept;
  logic               is_scan;
  logic [1:0]         status_now;
  ial_pkg::pos_t      pos_ext;
  ial_pkg::pos_t      cnt_ext;
  ial_pkg::cell_cmd_t cmd;
  ial_pkg::probe_t    probe_in;
  ial_pkg::probe_t    probe_out;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign pos_ext   = ial_pkg::pos_t'(req.position);
  assign cnt_ext   = ial_pkg::pos_t'(count);
  assign is_scan   = (req.mode == ial_pkg::OP_READ) || (req.mode == ial_pkg::OP_FIND);

  // Status and count bookkeeping
  always_comb begin
    status_now = ial_pkg::ST_OK;
    count_next = count;
    unique case (req.mode)
      ial_pkg::OP_APPEND: begin
        if (count >= ial_pkg::CAP_CNT) status_now = ial_pkg::ST_FULL;
        else count_next = count + ial_pkg::CNT_W'(1);
      end
      ial_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) status_now = ial_pkg::ST_RANGE;
        else if (count >= ial_pkg::CAP_CNT) status_now = ial_pkg::ST_FULL;
        else count_next = count + ial_pkg::CNT_W'(1);
      end
      ial_pkg::OP_ERASE: begin
        if (pos_ext >= cnt_ext) status_now = ial_pkg::ST_RANGE;
        else count_next = count - ial_pkg::CNT_W'(1);
      end
      ial_pkg::OP_READ, ial_pkg::OP_WRITE: begin
        if (pos_ext >= cnt_ext) status_now = ial_pkg::ST_RANGE;
      end
      default: status_now = ial_pkg::ST_OK;
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    cmd.upd = accept && (status_now == ial_pkg::ST_OK) && !is_scan;
    cmd.op  = req.mode;
    cmd.pos = pos_ext;
    cmd.val = ial_pkg::to_elem(req.element);
    cmd.cnt = cnt_ext;

    probe_in.active  = accept && is_scan;
    probe_in.is_find = (req.mode == ial_pkg::OP_FIND);
    probe_in.pos     = pos_ext;
    probe_in.val     = ial_pkg::to_elem(req.element);
    probe_in.hit     = 1'b0;
    probe_in.hit_idx = '0;
    probe_in.rdata   = '0;
  end

  ial_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .probe_in  (probe_in),
    .probe_out (probe_out)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = is_scan ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (probe_out.active) state_next = S_OUT;
      end
      S_OUT: begin
        if (rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) count <= count_next;
    end
  end

  // Result register; an out-of-range read reports zero
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_now;
      rd_q     <= '0;
      found_q  <= 1'b0;
      fidx_q   <= '0;
    end else if (state == S_SCAN && probe_out.active) begin
      rd_q    <= (!probe_out.is_find && probe_out.hit && status_q == ial_pkg::ST_OK) ?
                 ial_pkg::from_elem(probe_out.rdata) : 32'd0;
      found_q <= probe_out.is_find && probe_out.hit;
      fidx_q  <= (probe_out.is_find && probe_out.hit) ? probe_out.hit_idx[5:0] : 6'd0;
    end
  end

  assign rsp.valid       = (state == S_OUT);
  assign rsp.status      = status_q;
  assign rsp.read_value  = rd_q;
  assign rsp.found       = found_q;
  assign rsp.found_index = fidx_q;
  assign rsp.item_count  = cnt_ext[6:0];

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ial_pkg::CAP_CNT)
    else $error("count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request taken while a result is pending");

  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    accept && !is_scan |=> rsp.valid)
    else $error("non-search result not presented next cycle");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ial_pkg::ST_FULL |-> count == ial_pkg::CAP_CNT)
    else $error("list full reported below capacity");

  a_probe_exit: assert property (@(posedge clk) disable iff (rst)
    probe_out.active |-> state == S_SCAN)
    else $error("probe left the chain outside a search");

endmodule

`default_nettype wire
